/* src/abes_pkg.sv */
// Shared types and constants for the accelerometer burst smoother.
// Used by every module of the block; depends on nothing.

package abes_pkg;

    localparam int FRAC_BITS = 16;
    localparam int STATE_W   = 17 + FRAC_BITS;   // signed Q17.FRAC filter state
    localparam int K_W       = 16;               // smoothing weight, Q0.16
    localparam int SAMPLE_W  = 16;
    localparam int AXIS_W    = 2;
    localparam int POS_W     = 3;
    localparam int FIFO_AW   = 2;                // four-entry sample queue

    localparam logic [K_W-1:0]    K_RESET   = 16'd62259;   // 0.95
    localparam logic [POS_W-1:0]  POS_LAST  = 3'd5;        // Z high byte
    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
    localparam int                NUM_AXES  = 3;

    localparam logic [2:0] REG_SMOOTHING = 3'd0;  // byte address of smoothing_factor

    // one assembled sample as handed from the front to the filter
    typedef struct packed {
        logic [AXIS_W-1:0]          axis;
        logic signed [SAMPLE_W-1:0] raw;
        logic                       done;
    } t_sample;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

/* src/abes_front.sv */
// Byte assembler: pairs received bytes into signed samples and tags axis/end of burst.
// Depends on abes_pkg.

module abes_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [7:0]               i_byte,
    input  logic                     i_frame_start,
    input  abes_pkg::t_fifo_status   i_fifo_status,
    output logic                     o_ready,
    output logic                     o_push,
    output abes_pkg::t_sample        o_sample
);

    logic [abes_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                 r_low, n_low;
    logic [abes_pkg::POS_W-1:0] w_pos;
    logic                       w_take;

    assign o_ready = !i_fifo_status.full;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        // frame start (or an impossible position) restarts at the X low byte
        w_pos = (i_frame_start || (r_pos > abes_pkg::POS_LAST)) ? '0 : r_pos;
        n_pos = r_pos;
        n_low = r_low;
        o_push = 1'b0;
        o_sample.axis = w_pos[abes_pkg::POS_W-1:1];
        o_sample.raw  = $signed({i_byte, r_low});
        o_sample.done = (w_pos == abes_pkg::POS_LAST);
        if (w_take) begin
            if (!w_pos[0]) begin
                n_low = i_byte;
                n_pos = w_pos + 1'b1;
            end else begin
                o_push = 1'b1;
                n_pos  = o_sample.done ? '0 : w_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_low <= '0;
        end else begin
            r_pos <= n_pos;
            r_low <= n_low;
        end
    end

endmodule

/* src/abes_fifo.sv */
// Short sample queue between the byte assembler and the filter.
// Depends on abes_pkg.

module abes_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  abes_pkg::t_sample      i_sample,
    input  logic                   i_pop,
    output abes_pkg::t_sample      o_sample,
    output abes_pkg::t_fifo_status o_status
);

    localparam int DEPTH = 1 << abes_pkg::FIFO_AW;

    abes_pkg::t_sample              r_mem [DEPTH];
    logic [abes_pkg::FIFO_AW-1:0]   r_wr, r_rd;
    logic [abes_pkg::FIFO_AW:0]     r_cnt;
    logic                           w_push, w_pop;

    assign o_status.full  = (r_cnt == (abes_pkg::FIFO_AW+1)'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_push   = i_push && !o_status.full;
    assign w_pop    = i_pop && !o_status.empty;
    assign o_sample = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* src/abes_back.sv */
// Filter engine: per-axis EMA state, two-stage multiply/accumulate, output register.
// Depends on abes_pkg.

module abes_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [abes_pkg::K_W-1:0]            i_k,
    input  abes_pkg::t_sample                   i_sample,
    input  logic                                i_avail,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [abes_pkg::AXIS_W-1:0]         o_axis,
    output logic signed [abes_pkg::SAMPLE_W-1:0] o_raw,
    output logic signed [abes_pkg::SAMPLE_W-1:0] o_filt,
    output logic                                o_done
);

    localparam int SW   = abes_pkg::STATE_W;
    localparam int FB   = abes_pkg::FRAC_BITS;
    localparam int P1W  = SW + abes_pkg::K_W;      // state * k
    localparam int P2W  = abes_pkg::SAMPLE_W + 17; // raw * (1 - k)
    localparam longint HI_L = longint'(32767) <<< FB;
    localparam longint LO_L = -(longint'(32768) <<< FB);
    localparam logic signed [SW:0] HI = $signed((SW+1)'(HI_L));
    localparam logic signed [SW:0] LO = $signed((SW+1)'(LO_L));

    logic signed [SW-1:0] r_state [abes_pkg::NUM_AXES];

    // stage A -> B registers
    logic                               r_b_valid;
    logic [abes_pkg::AXIS_W-1:0]        r_b_axis;
    logic signed [abes_pkg::SAMPLE_W-1:0] r_b_raw, r_b_filt;
    logic                               r_b_done;
    logic signed [P1W-1:0]              r_b_p1;
    logic signed [P2W-1:0]              r_b_p2;

    // output register
    logic                               r_o_valid;
    logic [abes_pkg::AXIS_W-1:0]        r_o_axis;
    logic signed [abes_pkg::SAMPLE_W-1:0] r_o_raw, r_o_filt;
    logic                               r_o_done;

    logic                  w_b_ready, w_a_ready, w_hazard;
    logic signed [SW-1:0]  w_st, w_st_biased;
    logic signed [P1W-1:0] w_st_x, w_k_x, w_p1;
    logic signed [P2W-1:0] w_raw_x, w_omk_x, w_p2;
    logic signed [P1W:0]   w_acc;
    logic signed [SW:0]    w_next_full, w_next_clamp;
    logic signed [abes_pkg::SAMPLE_W-1:0] w_filt;

    assign w_b_ready = !r_o_valid || i_ready;
    assign w_a_ready = !r_b_valid || w_b_ready;
    // state of an axis still in stage B is not yet written back
    assign w_hazard  = r_b_valid && (r_b_axis == i_sample.axis);
    assign o_pop     = i_avail && w_a_ready && !w_hazard;

    // stage A: read state, old value truncated toward zero, both products
    always_comb begin
        w_st        = (i_sample.axis < abes_pkg::AXIS_W'(abes_pkg::NUM_AXES))
                      ? r_state[i_sample.axis] : '0;
        w_st_biased = w_st + (w_st[SW-1] ? SW'((1 << FB) - 1) : SW'(0));
        w_filt      = w_st_biased[FB +: abes_pkg::SAMPLE_W];
        w_st_x      = P1W'(w_st);
        w_k_x       = $signed(P1W'(i_k));
        w_p1        = w_st_x * w_k_x;
        w_raw_x     = P2W'(i_sample.raw);
        w_omk_x     = $signed(P2W'(17'h10000 - {1'b0, i_k}));
        w_p2        = w_raw_x * w_omk_x;
    end

    // stage B: sum, floor shift by 16, clamp
    always_comb begin
        w_acc        = (P1W+1)'(r_b_p1) + ((P1W+1)'(r_b_p2) <<< FB);
        w_next_full  = w_acc[P1W:abes_pkg::K_W];
        w_next_clamp = (w_next_full > HI) ? HI :
                       (w_next_full < LO) ? LO : w_next_full;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_axis <= i_sample.axis;
            r_b_raw  <= i_sample.raw;
            r_b_done <= i_sample.done;
            r_b_filt <= w_filt;
            r_b_p1   <= w_p1;
            r_b_p2   <= w_p2;
        end
        if (r_b_valid && w_b_ready) begin
            r_o_axis <= r_b_axis;
            r_o_raw  <= r_b_raw;
            r_o_filt <= r_b_filt;
            r_o_done <= r_b_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < abes_pkg::NUM_AXES; i++) begin
                r_state[i] <= '0;
            end
        end else begin
            if (w_a_ready) r_b_valid <= o_pop;
            if (w_b_ready) r_o_valid <= r_b_valid;
            if (r_b_valid && w_b_ready &&
                r_b_axis < abes_pkg::AXIS_W'(abes_pkg::NUM_AXES)) begin
                r_state[r_b_axis] <= w_next_clamp[SW-1:0];
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_axis  = r_o_axis;
    assign o_raw   = r_o_raw;
    assign o_filt  = r_o_filt;
    assign o_done  = r_o_done;

endmodule

/* src/accel_burst_exp_smoother_unit.sv */
// Top level of the accelerometer burst smoother: config register, assembler, queue, filter.
// Depends on abes_pkg, abes_front, abes_fifo, abes_back.
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+-------------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready   | tdata[7:0] rx_byte, tuser[0] frame_start
//  m_axis    | out | m_axis_tvalid/tready   | tdata raw/filtered, tuser axis, tlast done
//  apb cfg   | in  | psel & penable & pwrite| smoothing_factor at address 0
//
// One byte word is taken per cycle while the sample queue is not full; a result comes out for every second byte.
// The result word is registered in the queue when the high byte is taken, then in the stage B
// registers after the multiply, then in the output register after the accumulate.
// Two samples of the same axis back to back in the queue are not taken in a row: the second
// waits until the first has written the axis state back.
// s_axis_tready drops only when the four-entry sample queue is full; m_axis stalls
// backpressure the filter stages and then the queue.
// Reset (i_rst_n, synchronous) clears byte position, held byte, queue, pipeline valids and axis states, k to 0.95.

module accel_burst_exp_smoother_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] frame_start
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] raw_sample, [31:16] filtered_sample
    output logic [1:0]  m_axis_tuser,   // [1:0] axis
    output logic        m_axis_tlast,   // frame_done
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [abes_pkg::K_W-1:0]  r_k;
    logic                      w_cfg_hit;

    logic                      w_push, w_pop;
    abes_pkg::t_sample         w_front_sample, w_q_sample;
    abes_pkg::t_fifo_status    w_q_status;

    logic signed [abes_pkg::SAMPLE_W-1:0] w_raw, w_filt;

    // register index is paddr / 4; only index 0 exists
    assign pready    = 1'b1;
    assign w_cfg_hit = (paddr[2] == abes_pkg::REG_SMOOTHING[2]);
    assign prdata    = w_cfg_hit ? 32'(r_k) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= abes_pkg::K_RESET;
        end else if (psel && penable && pwrite && pready && w_cfg_hit) begin
            r_k <= pwdata[abes_pkg::K_W-1:0];
        end
    end

    abes_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .i_byte        (s_axis_tdata),
        .i_frame_start (s_axis_tuser[0]),
        .i_fifo_status (w_q_status),
        .o_ready       (s_axis_tready),
        .o_push        (w_push),
        .o_sample      (w_front_sample)
    );

    abes_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_sample (w_front_sample),
        .i_pop    (w_pop),
        .o_sample (w_q_sample),
        .o_status (w_q_status)
    );

    abes_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_k      (r_k),
        .i_sample (w_q_sample),
        .i_avail  (!w_q_status.empty),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_axis   (m_axis_tuser),
        .o_raw    (w_raw),
        .o_filt   (w_filt),
        .o_done   (m_axis_tlast)
    );

    assign m_axis_tdata = {w_filt, w_raw};

endmodule

/* src/abes_checker.sv */
// Port-level checks for the burst smoother, bound to the top level.
// Depends on abes_pkg and accel_burst_exp_smoother_unit.

module abes_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast,
    input logic        pready
);

    // end of burst is only ever flagged on a Z word
    a_last_on_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == abes_pkg::AXIS_Z)
        else $error("tlast on non-Z word");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= abes_pkg::AXIS_Z)
        else $error("axis code out of range");

    // nothing left over from before reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    a_no_wait: assert property (@(posedge i_clk) pready)
        else $error("config port inserted wait state");

endmodule

bind accel_burst_exp_smoother_unit abes_checker u_abes_checker (.*);

/* test/accel_burst_exp_smoother_unit_tb.sv */
// Testbench for accel_burst_exp_smoother_unit: drives byte words and APB weight writes,
// predicts every sample result and checks it field by field. Depends on abes_pkg and the RTL.
`timescale 1ns / 1ps

module accel_burst_exp_smoother_unit_tb;

    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     DRAIN_CYCLES = 16;      // pipeline is three deep, leave slack
    localparam int     HOLD_CYCLES  = 300;     // long result-side hold-off
    localparam longint STATE_MIN    =
        -longint'(32768) * (longint'(1) << abes_pkg::FRAC_BITS);
    localparam longint STATE_MAX    =
        longint'(32767) * (longint'(1) << abes_pkg::FRAC_BITS);
    localparam longint K_UNITY      = longint'(1) << abes_pkg::K_W;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic [0:0]  s_axis_tuser;   // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [15:0] raw_sample, [31:16] filtered_sample
    logic [1:0]  m_axis_tuser;   // [1:0] axis
    logic        m_axis_tlast;   // frame_done
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bit tx_gaps_on;
    bit rx_stalls_on;
    bit hold_off_req;
    int cycle_count;

    accel_burst_exp_smoother_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    typedef struct {
        logic [abes_pkg::AXIS_W-1:0]          axis;
        logic signed [abes_pkg::SAMPLE_W-1:0] raw;
        logic signed [abes_pkg::SAMPLE_W-1:0] filt;
        logic                                 done;
    } t_exp_sample;

    // Tracks burst position, held low byte and per-axis EMA state; queues expected samples.
    class t_scoreboard;
        logic [abes_pkg::K_W-1:0]   weight;
        logic [abes_pkg::POS_W-1:0] position;
        logic [7:0]                 held_low;
        longint                     axis_state [abes_pkg::NUM_AXES];
        t_exp_sample                expected_samples [$];
        int                         errors;

        function new();
            weight   = abes_pkg::K_RESET;
            position = '0;
            held_low = '0;
            errors   = 0;
            foreach (axis_state[i]) axis_state[i] = 0;
        endfunction

        function void note_byte(logic [7:0] b, logic frame_start);
            logic [abes_pkg::POS_W-1:0]  pos;
            logic [abes_pkg::AXIS_W-1:0] ax;
            longint                      cur;
            longint                      whole;
            longint                      acc;
            longint                      nxt;
            t_exp_sample                 s;
            pos = position;
            if (frame_start || pos > abes_pkg::POS_LAST) pos = '0;
            // even position: low byte only, no result
            if (!pos[0]) begin
                held_low = b;
                position = pos + 1'b1;
                return;
            end
            ax     = pos[2:1];
            cur    = axis_state[ax];
            s.axis = ax;
            s.raw  = {b, held_low};
            // previous state, truncated toward zero
            whole = (cur >= 0) ? (cur >>> abes_pkg::FRAC_BITS)
                               : -((-cur) >>> abes_pkg::FRAC_BITS);
            if (whole > 32767) whole = 32767;
            if (whole < -32768) whole = -32768;
            s.filt = whole[abes_pkg::SAMPLE_W-1:0];
            // state*k + raw*(1-k), scaled back by 16 with a floor shift
            acc = cur * longint'(weight)
                + (longint'(s.raw) * (longint'(1) << abes_pkg::FRAC_BITS))
                  * (K_UNITY - longint'(weight));
            nxt = acc >>> abes_pkg::K_W;
            if (nxt < STATE_MIN) nxt = STATE_MIN;
            if (nxt > STATE_MAX) nxt = STATE_MAX;
            axis_state[ax] = nxt;
            s.done   = (pos == abes_pkg::POS_LAST);
            position = s.done ? '0 : pos + 1'b1;
            expected_samples.push_back(s);
        endfunction

        function void report(string field, longint exp_val, longint got_val);
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, exp_val, got_val);
            errors++;
        endfunction

        function void check_sample(logic [31:0] data, logic [1:0] user, logic last);
            t_exp_sample e;
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected sample: expected none, got axis %0d raw %0d filt %0d",
                         $time, user, $signed(data[15:0]), $signed(data[31:16]));
                errors++;
                return;
            end
            e = expected_samples.pop_front();
            if (user !== e.axis) report("axis", e.axis, user);
            if ($signed(data[15:0]) !== e.raw) report("raw_sample", e.raw, $signed(data[15:0]));
            if ($signed(data[31:16]) !== e.filt)
                report("filtered_sample", e.filt, $signed(data[31:16]));
            if (last !== e.done) report("frame_done", e.done, last);
        endfunction
    endclass

    t_scoreboard sb;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] corners [4];
        corners = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        if ($urandom_range(0, 4) == 0) return corners[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    // one byte word; returns at the edge that accepts it
    task automatic send_byte(input logic [7:0] b, input logic frame_start);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid   = 1'b1;
        s_axis_tdata    = b;
        s_axis_tuser[0] = frame_start;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // drop valid, wait for every expected sample, then let the pipe empty
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_weight(input logic [abes_pkg::K_W-1:0] k);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = abes_pkg::REG_SMOOTHING;
        pwdata  = {{(32-abes_pkg::K_W){1'b0}}, k};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.weight = k;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // corner samples, bursts with and without frame start, restarts mid-pair
    task automatic run_directed();
        logic [8:0] seq [21];   // {frame_start, byte}
        seq = '{9'h100, 9'h080, 9'h0FF, 9'h07F, 9'h0FF, 9'h0FF,
                9'h001, 9'h000, 9'h000, 9'h000, 9'h080, 9'h0FF,
                9'h1AA, 9'h155, 9'h001,
                9'h112, 9'h034, 9'h000, 9'h080, 9'h0FF, 9'h07F};
        foreach (seq[i]) send_byte(seq[i][7:0], seq[i][8]);
    endtask

    // mostly whole bursts with random bytes, some cut short, some stray words
    task automatic run_bursts(input int n_items, input bit with_hold);
        int   sent;
        int   len;
        int   kind;
        bit   held;
        logic first_fs;
        logic fs;
        sent = 0;
        held = 0;
        while (sent < n_items) begin
            if (with_hold && !held && sent >= n_items / 3) begin
                hold_off_req = 1'b1;
                held = 1;
            end
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                len      = 6;
                first_fs = ($urandom_range(0, 3) != 0);
            end else if (kind == 8) begin
                len      = $urandom_range(1, 5);
                first_fs = 1'b1;
            end else begin
                len      = 1;
                first_fs = 1'($urandom_range(0, 1));
            end
            for (int i = 0; i < len; i++) begin
                fs = (i == 0) ? first_fs : 1'b0;
                send_byte(pick_byte(), fs);
                sent++;
            end
        end
    endtask

    // result-side ready: random stalls, plus a long hold-off on request
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = 0;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = HOLD_CYCLES;
            end else if (rx_stalls_on) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    // accepted words feed the prediction before the result on the same edge is checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tuser[0]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_sample(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d samples still expected", $time,
                     sb.expected_samples.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [abes_pkg::K_W-1:0] weights [5];
        sb              = new();
        cycle_count     = 0;
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        tx_gaps_on      = 1'b1;
        rx_stalls_on    = 1'b1;
        hold_off_req    = 1'b0;
        weights = '{16'd0, 16'hFFFF, 16'h8000,
                    16'($urandom_range(1, 65534)), 16'($urandom_range(1, 65534))};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset weight first, then min, max and a few in between
        run_directed();
        settle();
        for (int ph = 0; ph < 5; ph++) begin
            tx_gaps_on   = (ph != 0 && ph != 3);
            rx_stalls_on = (ph != 0 && ph != 4);
            write_weight(weights[ph]);
            run_bursts(150, ph == 1 || ph == 3);
            settle();
        end

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
src/abes_pkg.sv
src/abes_front.sv
src/abes_fifo.sv
src/abes_back.sv
src/accel_burst_exp_smoother_unit.sv
src/abes_checker.sv
test/accel_burst_exp_smoother_unit_tb.sv
